/* rtl/sspq_pkg.sv */
package sspq_pkg;

	// operation codes on the opcode input
	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctrl_t;

endpackage

/* rtl/stable_sorted_priority_queue_core.sv */
// Bounded priority queue of DEPTH entries held sorted in a chain of cells, smallest priority
// at the head; an enqueue lands behind all entries of equal priority, so ties leave in FIFO
// order. Each transaction on the input is an enqueue (opcode 0) or a dequeue of the head
// (opcode 1) and yields exactly one result transaction with the head, the count, an empty
// flag and an error flag (enqueue on full or dequeue on empty, queue unchanged). Every cell
// compares the new priority with its own entry in parallel and shifts toward or away from
// the head in the same cycle, so one transaction is taken per cycle; the result sits in an
// output register, and a new transaction is taken whenever that register is empty or being
// drained in the same cycle.
module stable_sorted_priority_queue_core
	import sspq_pkg::*;
#(
	parameter int DEPTH       = 16,
	parameter int VALUE_WIDTH = 32,
	parameter int PRIO_WIDTH  = 16,
	localparam int CNT_W      = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   opcode,
	input  logic [VALUE_WIDTH-1:0] item_value,
	input  logic [PRIO_WIDTH-1:0]  item_priority,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_WIDTH-1:0] head_value,
	output logic [PRIO_WIDTH-1:0]  head_priority,
	output logic [CNT_W-1:0]       entry_count,
	output logic                   is_empty,
	output logic                   op_error
);

	logic                   out_valid_q;
	logic                   op_error_q;
	logic [CNT_W-1:0]       count_q;
	logic                   accept;
	logic                   full;
	logic                   empty;
	logic                   fault;
	cell_ctrl_t             ctrl;
	logic [DEPTH-1:0]       occ;
	logic [DEPTH-1:0]       stays;
	logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
	logic [PRIO_WIDTH-1:0]  cell_prio  [DEPTH];

	// handshake and command decode
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	always_comb begin
		ctrl.push = 1'b0;
		ctrl.pop  = 1'b0;
		fault     = 1'b0;
		unique case (op_t'(opcode))
			OP_ENQUEUE: begin
				ctrl.push = accept && !full;
				fault     = full;
			end
			OP_DEQUEUE: begin
				ctrl.pop = accept && !empty;
				fault    = empty;
			end
			default: begin
				fault = 1'b1;
			end
		endcase
	end

	// chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   l_stays;
		logic [VALUE_WIDTH-1:0] l_value;
		logic [PRIO_WIDTH-1:0]  l_prio;
		logic [VALUE_WIDTH-1:0] r_value;
		logic [PRIO_WIDTH-1:0]  r_prio;

		assign occ[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_head
			assign l_stays = 1'b1;
			assign l_value = item_value;
			assign l_prio  = item_priority;
		end else begin : g_mid
			assign l_stays = stays[i-1];
			assign l_value = cell_value[i-1];
			assign l_prio  = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_value = '0;
			assign r_prio  = '0;
		end else begin : g_inner
			assign r_value = cell_value[i+1];
			assign r_prio  = cell_prio[i+1];
		end

		sspq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.PRIO_WIDTH (PRIO_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (occ[i]),
			.new_value  (item_value),
			.new_prio   (item_priority),
			.left_stays (l_stays),
			.left_value (l_value),
			.left_prio  (l_prio),
			.right_value(r_value),
			.right_prio (r_prio),
			.value      (cell_value[i]),
			.prio       (cell_prio[i]),
			.stays      (stays[i])
		);
	end

	// entry count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			op_error_q  <= 1'b0;
		end else begin
			if (ctrl.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				out_valid_q <= 1'b1;
				op_error_q  <= fault;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// cells only move on a transaction that also loads the result, so the head reads live
	assign out_valid     = out_valid_q;
	assign op_error      = op_error_q;
	assign entry_count   = count_q;
	assign is_empty      = empty;
	assign head_value    = empty ? '0 : cell_value[0];
	assign head_priority = empty ? '0 : cell_prio[0];

	// checks
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("no result after accepted transaction");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_prio[0] <= cell_prio[1]))
		else $error("head entries out of order");

	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && fault) |=> (op_error_q && $stable(count_q)))
		else $error("refused operation changed the count");

endmodule

/* rtl/sspq_cell.sv */
module sspq_cell
	import sspq_pkg::*;
#(
	parameter int VALUE_WIDTH = 32,
	parameter int PRIO_WIDTH  = 16
) (
	input  logic                   clk,
	input  cell_ctrl_t             ctrl,
	input  logic                   occupied,
	input  logic [VALUE_WIDTH-1:0] new_value,
	input  logic [PRIO_WIDTH-1:0]  new_prio,
	input  logic                   left_stays,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic [PRIO_WIDTH-1:0]  left_prio,
	input  logic [VALUE_WIDTH-1:0] right_value,
	input  logic [PRIO_WIDTH-1:0]  right_prio,
	output logic [VALUE_WIDTH-1:0] value,
	output logic [PRIO_WIDTH-1:0]  prio,
	output logic                   stays
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic [PRIO_WIDTH-1:0]  prio_q;
	logic [VALUE_WIDTH-1:0] value_d;
	logic [PRIO_WIDTH-1:0]  prio_d;
	logic                   load;

	// entry sorts at or ahead of the new item, so it keeps its slot
	assign stays = occupied && (prio_q <= new_prio);

	// pick the next entry: new item, left neighbor on insert, right neighbor on pop
	always_comb begin
		load    = 1'b0;
		value_d = value_q;
		prio_d  = prio_q;
		priority if (ctrl.push) begin
			if (!stays) begin
				load = 1'b1;
				if (left_stays) begin
					value_d = new_value;
					prio_d  = new_prio;
				end else begin
					value_d = left_value;
					prio_d  = left_prio;
				end
			end
		end else if (ctrl.pop) begin
			load    = 1'b1;
			value_d = right_value;
			prio_d  = right_prio;
		end
	end

	// entry storage, payload only
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= value_d;
			prio_q  <= prio_d;
		end
	end

	assign value = value_q;
	assign prio  = prio_q;

endmodule
